### src/smx_pkg.sv
package smx_pkg;

   localparam int unsigned DefDataDepth   = 64;
   localparam int unsigned DefReturnDepth = 64;
   localparam int unsigned DefMemCells    = 256;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned CmdWidth  = 5;
   localparam int unsigned OutDepthWidth = 7;

   // Primitive codes carried in the command field.
   typedef enum logic [CmdWidth-1:0] {
      CMD_LIT     = 5'd0,
      CMD_ADD     = 5'd1,
      CMD_SUB     = 5'd2,
      CMD_MUL     = 5'd3,
      CMD_DIV     = 5'd4,
      CMD_LT      = 5'd5,
      CMD_GT      = 5'd6,
      CMD_EQ      = 5'd7,
      CMD_DUP     = 5'd8,
      CMD_SWAP    = 5'd9,
      CMD_ROT     = 5'd10,
      CMD_NROT    = 5'd11,
      CMD_DROP    = 5'd12,
      CMD_TOR     = 5'd13,
      CMD_RFROM   = 5'd14,
      CMD_RFETCH  = 5'd15,
      CMD_FETCH   = 5'd16,
      CMD_STORE   = 5'd17,
      CMD_CELLS   = 5'd18,
      CMD_ZBRANCH = 5'd19,
      CMD_DOT     = 5'd20
   } cmd_type;

   typedef enum logic [1:0] {
      FLT_OK    = 2'd0,
      FLT_UNDER = 2'd1,
      FLT_OVER  = 2'd2,
      FLT_DIV0  = 2'd3
   } fault_type;

   // Control group from the sequencer to the divider.
   typedef struct packed {
      logic start;
      logic is_signed;
   } div_ctrl_type;

endpackage

### src/smx_if.sv
interface smx_req_if import smx_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CmdWidth-1:0]  command;
   logic signed [WordWidth-1:0] operand;

   modport source (output valid, output command, output operand, input ready);
   modport sink   (input valid, input command, input operand, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [WordWidth-1:0]  top_value;
   logic signed [WordWidth-1:0]  printed_value;
   logic                         branch_taken;
   logic signed [WordWidth-1:0]  branch_step;
   logic [1:0]                   fault;
   logic [OutDepthWidth-1:0]     stack_depth;

   modport source (output valid, output top_value, output printed_value,
                   output branch_taken, output branch_step, output fault,
                   output stack_depth, input ready);
   modport sink   (input valid, input top_value, input printed_value,
                   input branch_taken, input branch_step, input fault,
                   input stack_depth, output ready);
endinterface

### src/stack_machine_execute_unit.sv
// Sequence: an accepted request passes RD1, RD2, RD3, EXEC, WR and OUT for most primitives;
// divide adds DIV, fetch adds MEMRD and MEMCAP, and with a non power of two MEM_CELLS fetch and store
// add ADDR and MOD.
// Throughput: one request at a time, taken only in IDLE; the pace is set by the top three
// data stack reads and write-backs through the stack memory's single read and write ports.
// Reset (synchronous, active high) empties both stacks and the response register;
// memory contents are left as they are.
module stack_machine_execute_unit
   import smx_pkg::*;
#(
   parameter int unsigned DATA_DEPTH   = DefDataDepth,
   parameter int unsigned RETURN_DEPTH = DefReturnDepth,
   parameter int unsigned MEM_CELLS    = DefMemCells
) (
   input  logic       clock,
   input  logic       reset,
   smx_req_if.sink    req_chan,
   smx_rsp_if.source  rsp_chan
);

   localparam int unsigned DW  = $clog2(DATA_DEPTH + 1);
   localparam int unsigned DAW = $clog2(DATA_DEPTH);
   localparam int unsigned RW  = $clog2(RETURN_DEPTH + 1);
   localparam int unsigned RAW = $clog2(RETURN_DEPTH);
   localparam int unsigned MAW = $clog2(MEM_CELLS);
   localparam int unsigned XW  = DW + 2;
   localparam bit MemPow2 = ((MEM_CELLS & (MEM_CELLS - 1)) == 0);
   localparam int unsigned ModShift = WordWidth + MAW;
   localparam logic [63:0] ModRecip =
      ((64'd1 << ModShift) + 64'(MEM_CELLS) - 64'd1) / 64'(MEM_CELLS);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_RD1    = 12'b0000_0000_0010,
      ST_RD2    = 12'b0000_0000_0100,
      ST_RD3    = 12'b0000_0000_1000,
      ST_EXEC   = 12'b0000_0001_0000,
      ST_DIV    = 12'b0000_0010_0000,
      ST_ADDR   = 12'b0000_0100_0000,
      ST_MEMRD  = 12'b0000_1000_0000,
      ST_MEMCAP = 12'b0001_0000_0000,
      ST_WR     = 12'b0010_0000_0000,
      ST_OUT    = 12'b0100_0000_0000,
      ST_MOD    = 12'b1000_0000_0000
   } state_type;

   typedef logic [WordWidth-1:0] word_type;

   state_type state_ff, state_in;
   logic [DW-1:0] dd_ff, nd_ff, nd_c;
   logic [RW-1:0] rd_ff, rnd_ff, rnd_c;
   cmd_type  cmd_ff;
   word_type opnd_ff;
   word_type s0_ff, s1_ff, s2_ff, r_ff;
   word_type n0_ff, n1_ff, n2_ff, n0_c, n1_c, n2_c;
   fault_type fault_ff, flt_c;
   logic [2:0] wmask_ff, wmask_c;
   logic [1:0] k_ff;
   logic [MAW-1:0] addr_ff;
   word_type printed_ff, printed_c, step_ff, step_c;
   logic taken_ff, taken_c;
   logic chg_c;
   word_type alu_c;
   logic [2*WordWidth-1:0] prod_c;
   logic [2*WordWidth:0] mod_prod_c;
   word_type quot_ff, quot_c, mod_back_c, mod_rem_c;

   logic rsp_valid_ff;
   word_type rsp_top_ff, rsp_printed_ff, rsp_step_ff;
   logic rsp_taken_ff;
   fault_type rsp_fault_ff;
   logic [OutDepthWidth-1:0] rsp_depth_ff;

   logic [DAW-1:0] d_raddr, d_waddr;
   logic [DW-1:0]  d_rpos, d_wpos;
   word_type d_rdata, d_wdata;
   logic d_we;
   word_type r_rdata;
   logic r_we;
   word_type c_rdata;
   logic c_we;
   logic out_free;

   div_ctrl_type div_ctrl;
   word_type div_quot, div_rem, div_a, div_b;
   logic div_done;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Data stack memory: reads walk down from the top, writes go back in WR.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: d_rpos = dd_ff - DW'(1);
         ST_RD1:  d_rpos = dd_ff - DW'(2);
         ST_RD2:  d_rpos = dd_ff - DW'(3);
         default: d_rpos = '0;
      endcase
      d_raddr = d_rpos[DAW-1:0];
      d_wpos  = nd_ff - DW'(1) - DW'(k_ff);
      d_waddr = d_wpos[DAW-1:0];
      d_we    = (state_ff == ST_WR) && wmask_ff[k_ff];
      unique case (k_ff)
         2'd0:    d_wdata = n0_ff;
         2'd1:    d_wdata = n1_ff;
         default: d_wdata = n2_ff;
      endcase
   end

   assign r_we = (state_ff == ST_WR) && (k_ff == 2'd0) && (fault_ff == FLT_OK)
                 && (cmd_ff == CMD_TOR);
   assign c_we = (state_ff == ST_WR) && (k_ff == 2'd0) && (fault_ff == FLT_OK)
                 && (cmd_ff == CMD_STORE);

   smx_ram #(.WIDTH(WordWidth), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   smx_ram #(.WIDTH(WordWidth), .DEPTH(RETURN_DEPTH)) u_return_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (rd_ff[RAW-1:0]),
      .wdata (s0_ff),
      .raddr (RAW'(rd_ff - RW'(1))),
      .rdata (r_rdata)
   );

   smx_ram #(.WIDTH(WordWidth), .DEPTH(MEM_CELLS)) u_cell_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (addr_ff),
      .wdata (s1_ff),
      .raddr (addr_ff),
      .rdata (c_rdata)
   );

   // The divider serves the divide primitive.
   always_comb begin
      div_ctrl.is_signed = 1'b1;
      div_ctrl.start     = (state_ff == ST_EXEC) && chg_c && (cmd_ff == CMD_DIV);
      div_a = s1_ff;
      div_b = s0_ff;
   end

   smx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Cell address reduction when the cell count is not a power of two. A multiply
   // by the scaled reciprocal gives the exact quotient in ADDR, and a
   // multiply-subtract gives the remainder in the next state, MOD.
   always_comb begin
      mod_prod_c = (2*WordWidth+1)'(s0_ff) * (2*WordWidth+1)'(ModRecip[WordWidth:0]);
      quot_c     = WordWidth'(mod_prod_c >> ModShift);
      mod_back_c = quot_ff * WordWidth'(MEM_CELLS);
      mod_rem_c  = s0_ff - mod_back_c;
   end

   // Arithmetic and compare results for the binary primitives.
   always_comb begin
      prod_c = s1_ff * s0_ff;
      unique case (cmd_ff)
         CMD_ADD: alu_c = s1_ff + s0_ff;
         CMD_SUB: alu_c = s1_ff - s0_ff;
         CMD_MUL: alu_c = prod_c[WordWidth-1:0];
         CMD_LT:  alu_c = word_type'($signed(s1_ff) < $signed(s0_ff));
         CMD_GT:  alu_c = word_type'($signed(s1_ff) > $signed(s0_ff));
         CMD_EQ:  alu_c = word_type'(s1_ff == s0_ff);
         default: alu_c = '0;
      endcase
   end

   // Fault checks and the new top three entries of the data stack.
   always_comb begin
      flt_c     = FLT_OK;
      chg_c     = 1'b0;
      nd_c      = dd_ff;
      rnd_c     = rd_ff;
      n0_c      = s0_ff;
      n1_c      = s1_ff;
      n2_c      = s2_ff;
      printed_c = '0;
      taken_c   = 1'b0;
      step_c    = word_type'(1);
      unique case (cmd_ff)
         CMD_LIT: begin
            if (dd_ff >= DW'(DATA_DEPTH)) flt_c = FLT_OVER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff + DW'(1);
               n0_c = opnd_ff; n1_c = s0_ff; n2_c = s1_ff;
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_LT, CMD_GT, CMD_EQ: begin
            if (dd_ff < DW'(2)) flt_c = FLT_UNDER;
            else if (cmd_ff == CMD_DIV && s0_ff == '0) flt_c = FLT_DIV0;
            else begin
               chg_c = 1'b1; nd_c = dd_ff - DW'(1);
               n0_c = alu_c; n1_c = s2_ff;
            end
         end
         CMD_DUP: begin
            if (dd_ff < DW'(1)) flt_c = FLT_UNDER;
            else if (dd_ff >= DW'(DATA_DEPTH)) flt_c = FLT_OVER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff + DW'(1);
               n0_c = s0_ff; n1_c = s0_ff; n2_c = s1_ff;
            end
         end
         CMD_SWAP: begin
            if (dd_ff < DW'(2)) flt_c = FLT_UNDER;
            else begin
               chg_c = 1'b1; n0_c = s1_ff; n1_c = s0_ff;
            end
         end
         CMD_ROT, CMD_NROT: begin
            if (dd_ff < DW'(3)) flt_c = FLT_UNDER;
            else begin
               chg_c = 1'b1;
               if (cmd_ff == CMD_ROT) begin
                  n0_c = s2_ff; n1_c = s0_ff; n2_c = s1_ff;
               end else begin
                  n0_c = s1_ff; n1_c = s2_ff; n2_c = s0_ff;
               end
            end
         end
         CMD_DROP, CMD_ZBRANCH, CMD_DOT: begin
            if (dd_ff < DW'(1)) flt_c = FLT_UNDER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff - DW'(1);
               n0_c = s1_ff; n1_c = s2_ff;
               if (cmd_ff == CMD_DOT) printed_c = s0_ff;
               if (cmd_ff == CMD_ZBRANCH && s0_ff == '0) begin
                  taken_c = 1'b1; step_c = opnd_ff;
               end
            end
         end
         CMD_TOR: begin
            if (dd_ff < DW'(1)) flt_c = FLT_UNDER;
            else if (rd_ff >= RW'(RETURN_DEPTH)) flt_c = FLT_OVER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff - DW'(1); rnd_c = rd_ff + RW'(1);
               n0_c = s1_ff; n1_c = s2_ff;
            end
         end
         CMD_RFROM, CMD_RFETCH: begin
            if (rd_ff < RW'(1)) flt_c = FLT_UNDER;
            else if (dd_ff >= DW'(DATA_DEPTH)) flt_c = FLT_OVER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff + DW'(1);
               if (cmd_ff == CMD_RFROM) rnd_c = rd_ff - RW'(1);
               n0_c = r_ff; n1_c = s0_ff; n2_c = s1_ff;
            end
         end
         CMD_FETCH, CMD_CELLS: begin
            if (dd_ff < DW'(1)) flt_c = FLT_UNDER;
            else begin
               chg_c = 1'b1;
               if (cmd_ff == CMD_CELLS) n0_c = {s0_ff[WordWidth-2:0], 1'b0};
            end
         end
         CMD_STORE: begin
            if (dd_ff < DW'(2)) flt_c = FLT_UNDER;
            else begin
               chg_c = 1'b1; nd_c = dd_ff - DW'(2);
               n0_c = s2_ff;
            end
         end
         default: ;
      endcase
      // Only entries that were read or newly pushed are written back.
      for (int k = 0; k < 3; k++) begin
         wmask_c[k] = chg_c && (XW'(k) < XW'(nd_c))
                      && (XW'(nd_c) + XW'(2) >= XW'(dd_ff) + XW'(k));
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_RD1;
         ST_RD1:    state_in = ST_RD2;
         ST_RD2:    state_in = ST_RD3;
         ST_RD3:    state_in = ST_EXEC;
         ST_EXEC: begin
            if (chg_c && cmd_ff == CMD_DIV) state_in = ST_DIV;
            else if (chg_c && (cmd_ff == CMD_FETCH || cmd_ff == CMD_STORE)) begin
               if (!MemPow2) state_in = ST_ADDR;
               else if (cmd_ff == CMD_FETCH) state_in = ST_MEMRD;
               else state_in = ST_WR;
            end else state_in = ST_WR;
         end
         ST_DIV:    if (div_done) state_in = ST_WR;
         ST_ADDR:   state_in = ST_MOD;
         ST_MOD:    state_in = (cmd_ff == CMD_FETCH) ? ST_MEMRD : ST_WR;
         ST_MEMRD:  state_in = ST_MEMCAP;
         ST_MEMCAP: state_in = ST_WR;
         ST_WR:     if (k_ff == 2'd2) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dd_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC) k_ff <= '0;
         if (state_ff == ST_WR) k_ff <= k_ff + 2'd1;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            dd_ff        <= nd_ff;
            rd_ff        <= rnd_ff;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Operand capture, execute results and response payload.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff  <= cmd_type'(req_chan.command);
            opnd_ff <= req_chan.operand;
         end
         ST_RD1: begin
            s0_ff <= d_rdata;
            r_ff  <= r_rdata;
         end
         ST_RD2: s1_ff <= d_rdata;
         ST_RD3: s2_ff <= d_rdata;
         ST_EXEC: begin
            n0_ff      <= n0_c;
            n1_ff      <= n1_c;
            n2_ff      <= n2_c;
            nd_ff      <= nd_c;
            rnd_ff     <= rnd_c;
            fault_ff   <= flt_c;
            wmask_ff   <= wmask_c;
            printed_ff <= printed_c;
            taken_ff   <= taken_c;
            step_ff    <= step_c;
            addr_ff    <= s0_ff[MAW-1:0];
         end
         ST_DIV:    if (div_done) n0_ff <= div_quot;
         ST_ADDR:   quot_ff <= quot_c;
         ST_MOD:    addr_ff <= mod_rem_c[MAW-1:0];
         ST_MEMCAP: n0_ff <= c_rdata;
         ST_OUT: begin
            if (out_free) begin
               rsp_top_ff     <= (nd_ff != '0) ? n0_ff : '0;
               rsp_printed_ff <= printed_ff;
               rsp_taken_ff   <= taken_ff;
               rsp_step_ff    <= step_ff;
               rsp_fault_ff   <= fault_ff;
               rsp_depth_ff   <= OutDepthWidth'(nd_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.top_value     = rsp_top_ff;
   assign rsp_chan.printed_value = rsp_printed_ff;
   assign rsp_chan.branch_taken  = rsp_taken_ff;
   assign rsp_chan.branch_step   = rsp_step_ff;
   assign rsp_chan.fault         = rsp_fault_ff;
   assign rsp_chan.stack_depth   = rsp_depth_ff;

endmodule

### src/smx_ram.sv
module smx_ram
   import smx_pkg::*;
#(
   parameter int unsigned WIDTH = WordWidth,
   parameter int unsigned DEPTH = DefDataDepth
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### src/smx_divider.sv
module smx_divider
   import smx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [WordWidth-1:0] dividend,
   input  logic [WordWidth-1:0] divisor,
   output logic                 done,
   output logic [WordWidth-1:0] quotient,
   output logic [WordWidth-1:0] remainder
);

   localparam int unsigned CW = $clog2(WordWidth + 1);

   logic [WordWidth-1:0] q_ff, q_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] dv_ff, dv_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WordWidth:0]   shifted;
   logic [WordWidth:0]   diff;
   logic                 a_neg, b_neg;

   assign a_neg = ctrl.is_signed & dividend[WordWidth-1];
   assign b_neg = ctrl.is_signed & divisor[WordWidth-1];

   // Restoring division on magnitudes, one quotient bit per cycle.
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, q_ff[WordWidth-1]};
      diff    = shifted - {1'b0, dv_ff};
      if (ctrl.start) begin
         q_in    = a_neg ? (~dividend + 1'b1) : dividend;
         dv_in   = b_neg ? (~divisor + 1'b1) : divisor;
         neg_in  = a_neg ^ b_neg;
         rem_in  = '0;
         cnt_in  = CW'(WordWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WordWidth]) begin
            rem_in = diff[WordWidth-1:0];
            q_in   = {q_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[WordWidth-1:0];
            q_in   = {q_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      neg_ff <= neg_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign remainder = rem_ff;

endmodule
